// ===== rtl/array_priority_queue_unit_macros.svh =====
// Assertion macros for the priority queue checker.
// Needs clk and rst in scope at the point of use.
`ifndef ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define APQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// Next-cycle implication, off while reset is held.
`define APQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

// ===== rtl/apq_pkg.sv =====
// Shared types and constants for the array priority queue.
// No dependencies; used by the queue unit, the compare unit and the checker.
package apq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_priority;
    logic [3:0]         entry_count;
  } rsp_t;

  // One stored slot.
  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] pri;
  } entry_t;

  // Sequencer to minimum unit.
  typedef struct packed {
    logic             en;
    logic             first;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

endpackage

// ===== rtl/array_priority_queue_unit.sv =====
// Insert, full insert, empty remove: result strobe in the cycle after the request is taken.
// Remove: a scan streams every entry through the RAM read port to find the minimum, then
// a shift moves each later slot down by one to close the gap.
// One request at a time; busy is high once a remove on a non-empty queue is accepted, until done.
// Sync active-high reset empties the queue; slot contents stay undefined.
// The receiver cannot stall: each result shows for exactly one cycle.
module array_priority_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  apq_pkg::req_t req,
  output logic          done,
  output apq_pkg::rsp_t rsp
);

  // sequencer state
  apq_pkg::state_t            state, state_next;
  logic [apq_pkg::CNT_W-1:0]  count, count_next;   // entries held
  logic [apq_pkg::CNT_W-1:0]  iss, iss_next;       // next RAM read address
  logic                       dv, dv_next;         // RAM read data valid
  logic [apq_pkg::IDX_W-1:0]  dv_idx, dv_idx_next; // slot of that read data
  logic                       done_next;
  apq_pkg::rsp_t              res, res_next;

  // RAM port
  logic                       we;
  logic [apq_pkg::IDX_W-1:0]  waddr, raddr;
  apq_pkg::entry_t            wdata, rd_word;

  // minimum unit
  apq_pkg::scan_ctl_t         ctl;
  apq_pkg::entry_t            best;
  logic [apq_pkg::IDX_W-1:0]  best_idx_next;

  logic [apq_pkg::CNT_W-1:0]  last_idx;
  logic [apq_pkg::CNT_W+3:0]  cnt_ext;

  apq_ram #(
    .WIDTH ($bits(apq_pkg::entry_t)),
    .DEPTH (apq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_word)
  );

  apq_min u_min (
    .clk           (clk),
    .ctl           (ctl),
    .rd_word       (rd_word),
    .best          (best),
    .best_idx_next (best_idx_next)
  );

  assign last_idx = count - apq_pkg::CNT_W'(1);
  assign busy     = (state != apq_pkg::S_IDLE);
  assign rsp      = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apq_pkg::S_IDLE;
      count <= '0;
      dv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      dv    <= dv_next;
      done  <= done_next;
    end
    iss    <= iss_next;
    dv_idx <= dv_idx_next;
    res    <= res_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    iss_next    = iss;
    dv_next     = 1'b0;
    dv_idx_next = dv_idx;
    done_next   = 1'b0;
    res_next    = res;
    we          = 1'b0;
    waddr       = count[apq_pkg::IDX_W-1:0];
    wdata.val   = req.item_value;
    wdata.pri   = req.item_priority;
    raddr       = iss[apq_pkg::IDX_W-1:0];
    ctl.en      = 1'b0;
    ctl.first   = 1'b0;
    ctl.idx     = dv_idx;

    case (state)
      apq_pkg::S_IDLE: begin
        if (start) begin
          res_next.removed_value    = '0;
          res_next.removed_priority = '0;
          res_next.status           = apq_pkg::ST_DONE;
          if (req.action == apq_pkg::ACT_INSERT) begin
            done_next = 1'b1;
            if (count == apq_pkg::CNT_W'(apq_pkg::QUEUE_DEPTH)) begin
              res_next.status = apq_pkg::ST_FULL;
            end else begin
              we         = 1'b1;   // append at the tail
              count_next = count + apq_pkg::CNT_W'(1);
            end
          end else if (count == '0) begin
            done_next       = 1'b1;
            res_next.status = apq_pkg::ST_EMPTY;
          end else begin
            iss_next   = '0;
            state_next = apq_pkg::S_SCAN;
          end
        end
      end

      // stream slots 0..count-1 through the compare unit
      apq_pkg::S_SCAN: begin
        if (iss < count) begin
          dv_next     = 1'b1;
          dv_idx_next = iss[apq_pkg::IDX_W-1:0];
          iss_next    = iss + apq_pkg::CNT_W'(1);
        end
        if (dv) begin
          ctl.en    = 1'b1;
          ctl.first = (dv_idx == '0);
          if (apq_pkg::CNT_W'(dv_idx) == last_idx) begin
            dv_next    = 1'b0;
            iss_next   = apq_pkg::CNT_W'(best_idx_next) + apq_pkg::CNT_W'(1);
            state_next = apq_pkg::S_SHIFT;
          end
        end
      end

      // close the gap: slot j+1 read, then written to slot j
      apq_pkg::S_SHIFT: begin
        if (dv) begin
          we    = 1'b1;
          waddr = dv_idx - apq_pkg::IDX_W'(1);
          wdata = rd_word;
        end
        if (iss < count) begin
          dv_next     = 1'b1;
          dv_idx_next = iss[apq_pkg::IDX_W-1:0];
          iss_next    = iss + apq_pkg::CNT_W'(1);
        end else if (!dv) begin
          count_next                = last_idx;
          done_next                 = 1'b1;
          res_next.status           = apq_pkg::ST_DONE;
          res_next.removed_value    = best.val;
          res_next.removed_priority = best.pri;
          state_next                = apq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = apq_pkg::S_IDLE;
      end
    endcase

    // count reported masked to four bits
    cnt_ext = {4'b0000, count_next};
    if (done_next) begin
      res_next.entry_count = cnt_ext[3:0];
    end
  end

endmodule

// ===== rtl/apq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/apq_min.sv =====
// Signed compare unit: keeps the running minimum-priority entry.
// Depends on apq_pkg.
module apq_min (
  input  logic                      clk,
  input  apq_pkg::scan_ctl_t        ctl,
  input  apq_pkg::entry_t           rd_word,
  output apq_pkg::entry_t           best,
  output logic [apq_pkg::IDX_W-1:0] best_idx_next
);

  logic                      take;
  logic [apq_pkg::IDX_W-1:0] best_idx;

  // strict less: on ties the lower slot stays
  assign take = ctl.en && (ctl.first || (rd_word.pri < best.pri));
  assign best_idx_next = take ? ctl.idx : best_idx;

  always_ff @(posedge clk) begin
    if (take) begin
      best     <= rd_word;
      best_idx <= ctl.idx;
    end
  end

endmodule

// ===== rtl/apq_checker.sv =====
// Port-level checks for the array priority queue, bound to the top level.
// Depends on apq_pkg and array_priority_queue_unit_macros.svh.
`include "array_priority_queue_unit_macros.svh"

module apq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input apq_pkg::req_t req,
  input logic          done,
  input apq_pkg::rsp_t rsp
);

  // insert always completes in the cycle after it is taken and leaves the block free
  `APQ_ASSERT_NEXT(a_insert_done, start && !busy && req.action == apq_pkg::ACT_INSERT, done && !busy)

  // a remove either answers at once (empty) or keeps the block busy
  `APQ_ASSERT_NEXT(a_remove_busy, start && !busy && req.action == apq_pkg::ACT_REMOVE, busy || done)

  // the block only leaves busy by delivering its result
  `APQ_ASSERT_NOW(a_busy_ends_done, !$past(rst) && $fell(busy), done)

  // no removed payload unless a remove succeeded
  `APQ_ASSERT_NOW(a_fail_zero, done && rsp.status != apq_pkg::ST_DONE, rsp.removed_value == 0 && rsp.removed_priority == 0)

  // an empty report always shows an empty queue
  `APQ_ASSERT_NOW(a_empty_count, done && rsp.status == apq_pkg::ST_EMPTY, rsp.entry_count == 4'd0)

endmodule

bind array_priority_queue_unit apq_checker u_apq_checker (.*);

// ===== tb/array_priority_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for array_priority_queue_unit: directed and random requests.
// Depends on apq_pkg for the request/response structs and codes, and on the RTL alone.
module array_priority_queue_unit_tb;

  localparam int DEPTH = apq_pkg::QUEUE_DEPTH;
  // Settle time after the last result is well past the slowest remove.
  localparam int SETTLE_CYCLES = 4 * DEPTH + 20;
  localparam int DRAIN_LIMIT = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  apq_pkg::req_t req;
  apq_pkg::rsp_t rsp;

  array_priority_queue_unit dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // Shadow copy of the queue contents, kept in arrival order like the block's store.
  logic signed [31:0] pq_values     [DEPTH];
  logic signed [31:0] pq_priorities [DEPTH];
  int unsigned        pq_count;

  // Responses still owed by the block, oldest first.
  apq_pkg::rsp_t owed_responses[$];

  int error_count;
  int checked_count;
  int n_insert;
  int n_full;
  int n_remove;
  int n_empty;
  // Idle pattern on the request side: 0 = back to back, 1 = mostly short, 2 = long gaps too.
  int gap_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow queue and returns the response it should produce.
  function automatic apq_pkg::rsp_t apply_queue_op(input apq_pkg::req_t r);
    apq_pkg::rsp_t o;
    int            best;
    o = '0;
    o.status = apq_pkg::ST_DONE;
    if (r.action == apq_pkg::ACT_INSERT) begin
      if (pq_count >= DEPTH) begin
        o.status = apq_pkg::ST_FULL;
      end else begin
        pq_values[pq_count]     = r.item_value;
        pq_priorities[pq_count] = r.item_priority;
        pq_count++;
      end
    end else if (pq_count == 0) begin
      o.status = apq_pkg::ST_EMPTY;
    end else begin
      // Strict less-than keeps the lowest slot on a tie.
      best = 0;
      for (int i = 1; i < pq_count; i++) begin
        if ($signed(pq_priorities[i]) < $signed(pq_priorities[best])) best = i;
      end
      o.removed_value    = pq_values[best];
      o.removed_priority = pq_priorities[best];
      for (int i = best; i + 1 < pq_count; i++) begin
        pq_values[i]     = pq_values[i + 1];
        pq_priorities[i] = pq_priorities[i + 1];
      end
      pq_count--;
    end
    o.entry_count = 4'(pq_count);
    return o;
  endfunction

  // Issues one request and holds it until the block takes it (start high, busy low at an
  // edge). With no gap, start stays high into the next request, so it is never dropped and
  // raised within one time step.
  task automatic send_request(input apq_pkg::action_t act, input logic [31:0] val,
                              input logic [31:0] pri);
    apq_pkg::req_t r;
    int            gap;
    int            roll;
    apq_pkg::rsp_t want;
    r.action        = act;
    r.item_value    = val;
    r.item_priority = pri;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    want = apply_queue_op(r);
    owed_responses.push_back(want);
    if (act == apq_pkg::ACT_INSERT) begin
      n_insert++;
      if (want.status == apq_pkg::ST_FULL) n_full++;
    end else begin
      n_remove++;
      if (want.status == apq_pkg::ST_EMPTY) n_empty++;
    end
    roll = $urandom_range(99);
    gap  = 0;
    if (gap_mode == 1) begin
      if (roll >= 70) gap = $urandom_range(1, 3);
    end else if (gap_mode == 2) begin
      if (roll >= 85) gap = $urandom_range(8, 30);
      else if (roll >= 45) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Empty queue: remove must report empty with zeroed data, whatever the payload says; then one insert and its remove.
  task automatic test_remove_when_empty();
    send_request(apq_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(apq_pkg::ACT_REMOVE, 32'h0000_0000, 32'h8000_0000);
    send_request(apq_pkg::ACT_INSERT, 32'h1234_5678, 32'h0000_0007);
    send_request(apq_pkg::ACT_REMOVE, $urandom(), $urandom());
  endtask

  // Fill to capacity with extreme values and priorities (including a tie on the most
  // negative one), then try to insert past the top.
  task automatic test_fill_and_overflow();
    logic [31:0] pri_set [8];
    logic [31:0] val_set [8];
    pri_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h8000_0000, 32'h0000_0005, 32'h7FFF_FFFF};
    val_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE};
    for (int i = 0; i < DEPTH; i++) begin
      send_request(apq_pkg::ACT_INSERT, val_set[i % 8], pri_set[i % 8]);
    end
    send_request(apq_pkg::ACT_INSERT, 32'hDEAD_BEEF, 32'h8000_0000);
    send_request(apq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Drain everything: checks min order, tie order and the gap close, then one extra remove.
  task automatic test_drain_order();
    for (int i = 0; i <= DEPTH; i++) begin
      send_request(apq_pkg::ACT_REMOVE, $urandom(), $urandom());
    end
  endtask

  // Phases of random traffic, each with its own insert/remove mix and idle pattern, so the
  // queue swings between full and empty. Priorities lean on a narrow band to force ties.
  task automatic test_random_traffic(input int total);
    int               sent;
    int               phase_len;
    int               remove_pct;
    int               sel;
    logic [31:0]      pri;
    apq_pkg::action_t act;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(2))
        0: remove_pct = 30;
        1: remove_pct = 50;
        default: remove_pct = 70;
      endcase
      gap_mode = $urandom_range(2);
      for (int k = 0; k < phase_len && sent < total; k++) begin
        sel = $urandom_range(99);
        if (sel < 40) pri = $urandom_range(4) - 2;
        else if (sel < 50) pri = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else pri = $urandom();
        if ($urandom_range(99) < remove_pct) act = apq_pkg::ACT_REMOVE;
        else act = apq_pkg::ACT_INSERT;
        send_request(act, $urandom(), pri);
        sent++;
      end
    end
  endtask

  // Response checker: every done pulse must match the oldest owed response.
  always @(posedge clk) begin
    apq_pkg::rsp_t want;
    if (!rst && done) begin
      if (owed_responses.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual %p", $time, rsp);
        error_count++;
      end else begin
        want = owed_responses.pop_front();
        checked_count++;
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, rsp.status);
          error_count++;
        end
        if (rsp.removed_value !== want.removed_value) begin
          $display("%0t: removed_value mismatch: expected %0d, actual %0d",
                   $time, want.removed_value, rsp.removed_value);
          error_count++;
        end
        if (rsp.removed_priority !== want.removed_priority) begin
          $display("%0t: removed_priority mismatch: expected %0d, actual %0d",
                   $time, want.removed_priority, rsp.removed_priority);
          error_count++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                   $time, want.entry_count, rsp.entry_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    start         = 1'b0;
    req           = '0;
    rst           = 1'b1;
    pq_count      = 0;
    error_count   = 0;
    checked_count = 0;
    n_insert      = 0;
    n_full        = 0;
    n_remove      = 0;
    n_empty       = 0;
    gap_mode      = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    gap_mode = 1;
    test_remove_when_empty();
    gap_mode = 0;
    test_fill_and_overflow();
    gap_mode = 2;
    test_drain_order();
    test_random_traffic(1625);
    start <= 1'b0;

    // Let outstanding responses come back, then watch for stray strobes.
    waited = 0;
    while (owed_responses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived, expected next %p, actual none",
               $time, owed_responses.size(), owed_responses[0]);
      error_count += owed_responses.size();
    end

    $display("Covered %0d inserts (%0d rejected as full) and %0d removes (%0d on empty).",
             n_insert, n_full, n_remove, n_empty);
    $display("Checked %0d responses, %0d mismatches.", checked_count, error_count);
    if (error_count == 0) begin
      $display("array_priority_queue_unit_tb: PASS");
    end else begin
      $display("array_priority_queue_unit_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("array_priority_queue_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== array_priority_queue_unit.f =====
+incdir+rtl
rtl/apq_pkg.sv
rtl/apq_ram.sv
rtl/apq_min.sv
rtl/array_priority_queue_unit.sv
rtl/apq_checker.sv
tb/array_priority_queue_unit_tb.sv
